FILE: rtl/core/indic_break_tailor_unit_assert.svh
// Assertion macros for the Indic break tailoring unit.
// Included by the top level; relies on no other file.
`ifndef INDIC_BREAK_TAILOR_UNIT_ASSERT_SVH
`define INDIC_BREAK_TAILOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define IBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define IBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ibt_pkg.sv
// Shared types, code point constants and register indexes of the Indic break tailoring unit.
// No dependencies; used by every module of the block.
`default_nettype none

package ibt_pkg;

	localparam int FLAGS_W     = 16;
	localparam int CP_W        = 21;
	localparam int CFG_INDEX_W = 3;
	localparam int QUEUE_DEPTH = 4;

	// Item kinds
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_SINHALA   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CURSOR    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_BRK  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE_BRK  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE_NA   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_BACKSPACE = 3'd5;

	// Code points
	localparam logic [CP_W-1:0] CP_SI_VIRAMA  = 21'h000DCA;
	localparam logic [CP_W-1:0] CP_ZWJ        = 21'h00200D;
	localparam logic [CP_W-1:0] CP_ZWNJ       = 21'h00200C;
	localparam logic [CP_W-1:0] CP_SI_CONS_LO = 21'h000D9A;
	localparam logic [CP_W-1:0] CP_SI_CONS_HI = 21'h000DC6;

	typedef struct packed {
		logic                op;
		logic [CP_W-1:0]     code_point;
		logic [FLAGS_W-1:0]  flags_in;
	} in_item_t;

	typedef struct packed {
		logic [FLAGS_W-1:0]  flags_out;
		logic                last;
	} out_item_t;

	typedef struct packed {
		logic                sinhala;
		logic [FLAGS_W-1:0]  cursor_mask;
		logic [FLAGS_W-1:0]  char_mask;
		logic [FLAGS_W-1:0]  line_mask;
		logic [FLAGS_W-1:0]  line_na;
		logic [FLAGS_W-1:0]  bs_mask;
	} cfg_t;

	// Character class bits; all clear for code point 0 (no character)
	typedef struct packed {
		logic nz;
		logic zwj;
		logic zwnj;
		logic si_virama;
		logic si_cons;
		logic virama;
		logic nukta;
	} cp_class_t;

	typedef struct packed {
		logic                op;
		cp_class_t           cls;
		logic [FLAGS_W-1:0]  flags;
	} q_item_t;

	typedef enum logic {
		BK_STREAM,
		BK_FLUSH
	} bk_state_t;

	typedef struct packed {
		logic [1:0] held;
		logic       flushing;
		logic       pop;
		logic       emit_last;
	} bk_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/ibt_front.sv
// Front end: input handshake and code point classification into queue words.
// Depends on ibt_pkg.
`default_nettype none

module ibt_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  ibt_pkg::in_item_t  in_data,
	input  logic               q_full,
	output logic               push,
	output ibt_pkg::q_item_t   push_item
);

	function automatic ibt_pkg::cp_class_t classify(input logic [ibt_pkg::CP_W-1:0] c);
		ibt_pkg::cp_class_t r;
		r.nz        = (c != '0);
		r.zwj       = (c == ibt_pkg::CP_ZWJ);
		r.zwnj      = (c == ibt_pkg::CP_ZWNJ);
		r.si_virama = (c == ibt_pkg::CP_SI_VIRAMA);
		r.si_cons   = (c >= ibt_pkg::CP_SI_CONS_LO) && (c <= ibt_pkg::CP_SI_CONS_HI);
		r.virama    = (c == 21'h09CD) || (c == 21'h0ACD) || (c == 21'h094D) ||
			(c == 21'h0CCD) || (c == 21'h0D4D) || (c == 21'h0B4D) ||
			(c == 21'h0A4D) || (c == 21'h0BCD) || (c == 21'h0C4D);
		r.nukta     = (c >= 21'h09DC && c <= 21'h09DF) || (c >= 21'h0958 && c <= 21'h095F) ||
			(c == 21'h0931) || (c >= 21'h0CC7 && c <= 21'h0CC8) ||
			(c >= 21'h0CCA && c <= 21'h0CCB) || (c >= 21'h0BCA && c <= 21'h0BCC) ||
			(c == 21'h0C47) || (c == 21'h0C48) || (c == 21'h0B48) ||
			(c == 21'h0B4B) || (c == 21'h0B4C) || (c >= 21'h0A59 && c <= 21'h0A5C) ||
			(c == 21'h0A5E) || (c == 21'h0A33) || (c == 21'h0A36) ||
			(c == 21'h09CB) || (c == 21'h09CC) || (c >= 21'h0D4A && c <= 21'h0D4C);
		return r;
	endfunction

	// Take a word whenever the queue has room
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// Classify the code point; an end word carries no character
	always_comb begin
		push_item.op    = in_data.op;
		push_item.flags = in_data.flags_in;
		if (in_data.op == ibt_pkg::OP_END) begin
			push_item.cls = '0;
		end else begin
			push_item.cls = classify(in_data.code_point);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ibt_queue.sv
// Small register queue between the front end and the tailoring back end.
// Depends on ibt_pkg.
`default_nettype none

module ibt_queue #(
	parameter int DEPTH = ibt_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ibt_pkg::q_item_t  push_item,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output ibt_pkg::q_item_t  head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ibt_pkg::q_item_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ibt_back.sv
// Back end: three-position tailoring window, end-of-text flush and output register.
// Depends on ibt_pkg.
`default_nettype none

module ibt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ibt_pkg::cfg_t        cfg,
	input  logic                 head_valid,
	input  ibt_pkg::q_item_t     head,
	output logic                 head_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ibt_pkg::out_item_t   out_data,
	output ibt_pkg::bk_status_t  status
);

	localparam logic [1:0] HELD_MAX = 2'd2;

	typedef struct packed {
		logic [ibt_pkg::FLAGS_W-1:0] f0;
		logic [ibt_pkg::FLAGS_W-1:0] f1;
		logic [ibt_pkg::FLAGS_W-1:0] f2;
		logic                        conj;
	} tailor_t;

	// Suppress: drop cursor, char and line break bits, mark line break not allowed
	function automatic logic [ibt_pkg::FLAGS_W-1:0] suppress(input ibt_pkg::cfg_t c,
		input logic [ibt_pkg::FLAGS_W-1:0] f);
		return (f & ~(c.cursor_mask | c.char_mask | c.line_mask)) | c.line_na;
	endfunction

	// Tailor the oldest character of the window
	function automatic tailor_t tailor(input ibt_pkg::cfg_t c,
		input ibt_pkg::cp_class_t c0, input ibt_pkg::cp_class_t c1,
		input ibt_pkg::cp_class_t c2, input ibt_pkg::cp_class_t prev, input logic conj,
		input logic [ibt_pkg::FLAGS_W-1:0] f0, input logic [ibt_pkg::FLAGS_W-1:0] f1,
		input logic [ibt_pkg::FLAGS_W-1:0] f2);
		tailor_t r;
		r.f0   = f0;
		r.f1   = f1;
		r.f2   = f2;
		r.conj = conj;
		if (c0.nukta) begin
			r.f1 = r.f1 & ~c.bs_mask;
		end
		if (c.sinhala) begin
			if ((c0.si_virama && c1.zwj) || (c0.zwj && c1.si_virama)) begin
				r.f0   = suppress(c, r.f0);
				r.f1   = suppress(c, r.f1);
				r.conj = 1'b1;
			end else if (conj && (prev.zwj || prev.si_virama) && c0.si_cons) begin
				r.f0   = suppress(c, r.f0);
				r.conj = 1'b0;
			end else if (!conj && prev.si_virama && !c0.zwj) begin
				r.f0 = r.f0 | c.cursor_mask;
			end
		end else if (prev.nz && (c0.zwj || c0.zwnj)) begin
			r.f0 = suppress(c, r.f0);
			if (c1.nz) begin
				r.f1 = suppress(c, r.f1);
				if (c2.nz && c1.virama) begin
					r.f2 = suppress(c, r.f2);
				end
			end
		end
		return r;
	endfunction

	ibt_pkg::bk_state_t           state_q;
	ibt_pkg::bk_state_t           state_d;
	logic [1:0]                   held_q;
	ibt_pkg::cp_class_t           cls_q [2];
	logic [ibt_pkg::FLAGS_W-1:0]  flags_q [2];
	ibt_pkg::cp_class_t           prev_q;
	logic                         conj_q;
	logic                         out_valid_q;
	ibt_pkg::out_item_t           out_q;

	ibt_pkg::cp_class_t           vc [3];
	logic [ibt_pkg::FLAGS_W-1:0]  vf [3];
	tailor_t                      t;
	logic                         head_end;
	logic                         out_free;
	logic                         do_fill;
	logic                         do_step;
	logic                         do_final;
	logic                         flushing;
	ibt_pkg::out_item_t           emit;

	assign flushing = (state_q == ibt_pkg::BK_FLUSH);
	assign head_end = (head.op == ibt_pkg::OP_END);

	// Assemble the window: held characters plus the queue head at the fill position
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vc[i] = '0;
			vf[i] = '0;
		end
		for (int i = 0; i < 2; i++) begin
			if (2'(i) < held_q) begin
				vc[i] = cls_q[i];
				vf[i] = flags_q[i];
			end
		end
		case (held_q)
			2'd0: begin
				vc[0] = head_end ? '0 : head.cls;
				vf[0] = flushing ? flags_q[0] : head.flags;
			end
			2'd1: begin
				vc[1] = head_end ? '0 : head.cls;
				vf[1] = flushing ? flags_q[1] : head.flags;
			end
			2'd2: begin
				vc[2] = head_end ? '0 : head.cls;
				vf[2] = head.flags;
			end
			default: begin
			end
		endcase
	end

	assign t = tailor(cfg, vc[0], vc[1], vc[2], prev_q, conj_q, vf[0], vf[1], vf[2]);

	// Next state: enter flush on an end word with characters held, leave on the final word
	always_comb begin
		state_d = state_q;
		case (state_q)
			ibt_pkg::BK_STREAM: begin
				if (do_step && head_end && (held_q != 2'd0)) begin
					state_d = ibt_pkg::BK_FLUSH;
				end
			end
			ibt_pkg::BK_FLUSH: begin
				if (do_final) begin
					state_d = ibt_pkg::BK_STREAM;
				end
			end
			default: state_d = ibt_pkg::BK_STREAM;
		endcase
	end

	// Step control: fill the window, tailor one character, or emit the end word
	always_comb begin
		out_free = !out_valid_q || out_ready;
		do_fill  = head_valid && !head_end && (held_q != HELD_MAX);
		do_step  = head_valid && out_free && (head_end || (held_q == HELD_MAX));
		do_final = do_step && head_end && (held_q == 2'd0);
		head_pop = do_fill || (do_step && (!head_end || (held_q == 2'd0)));
		emit.flags_out = do_final ? vf[0] : t.f0;
		emit.last      = do_final;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ibt_pkg::BK_STREAM;
			held_q      <= '0;
			prev_q      <= '0;
			conj_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_fill) begin
				held_q <= held_q + 2'd1;
			end else if (do_final) begin
				held_q <= '0;
				prev_q <= '0;
				conj_q <= 1'b0;
			end else if (do_step) begin
				prev_q <= vc[0];
				conj_q <= t.conj;
				if (head_end) begin
					held_q <= held_q - 2'd1;
				end
			end
			if (do_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Window and output payload: load, shift, hold
	always_ff @(posedge clk) begin
		if (do_fill) begin
			cls_q[held_q[0]]   <= head.cls;
			flags_q[held_q[0]] <= head.flags;
		end else if (do_step && !do_final) begin
			cls_q[0]   <= vc[1];
			cls_q[1]   <= vc[2];
			flags_q[0] <= t.f1;
			flags_q[1] <= t.f2;
		end
		if (do_step) begin
			out_q <= emit;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_data         = out_q;
	assign status.held      = held_q;
	assign status.flushing  = flushing;
	assign status.pop       = head_pop;
	assign status.emit_last = do_final;

endmodule

`default_nettype wire

FILE: rtl/core/indic_break_tailor_unit.sv
// Indic break tailoring unit. A code point word is accepted every cycle while the input queue
// has room; each one, once two characters are held, yields one tailored break word two
// positions late, and that result is held in the single-word output register. An end-of-text word
// yields one result per held character plus the final word (marked last), one per cycle while
// the output is not stalled. A four-entry queue lets input and output stall independently.
// Registers are written through the plain write port; the user must write them only while the
// unit is idle, as the block itself does not enforce it. There is no clearing pass after reset.
// Depends on ibt_pkg, ibt_front, ibt_queue, ibt_back and the assertion macro header.
`default_nettype none

`include "indic_break_tailor_unit_assert.svh"

module indic_break_tailor_unit #(
	parameter int QUEUE_DEPTH = ibt_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ibt_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output ibt_pkg::out_item_t                 out_data,
	input  logic                               cfg_we,
	input  logic [ibt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ibt_pkg::FLAGS_W-1:0]        cfg_data
);

	ibt_pkg::cfg_t       cfg_q;
	logic                q_full;
	logic                q_push;
	ibt_pkg::q_item_t    q_push_item;
	logic                q_pop;
	logic                q_valid;
	ibt_pkg::q_item_t    q_head;
	ibt_pkg::bk_status_t bk_status;

	// Register write decode; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ibt_pkg::CFG_SINHALA:   cfg_q.sinhala     <= cfg_data[0];
				ibt_pkg::CFG_CURSOR:    cfg_q.cursor_mask <= cfg_data;
				ibt_pkg::CFG_CHAR_BRK:  cfg_q.char_mask   <= cfg_data;
				ibt_pkg::CFG_LINE_BRK:  cfg_q.line_mask   <= cfg_data;
				ibt_pkg::CFG_LINE_NA:   cfg_q.line_na     <= cfg_data;
				ibt_pkg::CFG_BACKSPACE: cfg_q.bs_mask     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ibt_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_full    (q_full),
		.push      (q_push),
		.push_item (q_push_item)
	);

	ibt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	ibt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (q_valid),
		.head       (q_head),
		.head_pop   (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.status     (bk_status)
	);

	// Window never holds more than two untailored characters between words
	`IBT_ASSERT_NOW(a_held_max, clk, arst_n, 1'b1, bk_status.held != 2'd3, "window overfilled")
	// A flush only runs with its end word still at the queue head
	`IBT_ASSERT_NOW(a_flush_head, clk, arst_n, bk_status.flushing, q_valid && (q_head.op == ibt_pkg::OP_END), "flush without end word")
	// The final word retires the end word
	`IBT_ASSERT_NOW(a_last_pops, clk, arst_n, bk_status.emit_last, bk_status.pop, "final word without pop")
	// After the final word the stream state is back to empty
	`IBT_ASSERT_NEXT(a_end_clears, clk, arst_n, bk_status.emit_last, (bk_status.held == 2'd0) && !bk_status.flushing, "state not cleared after end")

endmodule

`default_nettype wire
